[rtl/srm_pkg.sv]
package srm_pkg;

	// Reset values of the configuration registers.
	localparam logic [7:0]  DEVICE_ID_RESET   = 8'd66;
	localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;

	// Bit 0 of the device address marks a read.
	localparam logic [7:0] READ_BIT = 8'h01;

	// Bus idle levels: clock high, data high, master driving.
	localparam logic [2:0] LINES_IDLE = 3'b111;

	// Configuration register indexes.
	typedef enum logic {
		CFG_DEVICE_ID   = 1'b0,
		CFG_HALF_PERIOD = 1'b1
	} cfg_reg_t;

	// Protocol phases; each one holds the line levels for a half period.
	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_S1   = 5'd1,
		PH_S2   = 5'd2,
		PH_BLO  = 5'd3,
		PH_BHI  = 5'd4,
		PH_ALO  = 5'd5,
		PH_AHI  = 5'd6,
		PH_GAP1 = 5'd7,
		PH_GAP2 = 5'd8,
		PH_P1   = 5'd9,
		PH_P2   = 5'd10,
		PH_P3   = 5'd11,
		PH_MID1 = 5'd12,
		PH_MID2 = 5'd13,
		PH_RLO  = 5'd14,
		PH_RHI  = 5'd15,
		PH_N1   = 5'd16,
		PH_N2   = 5'd17,
		PH_N3   = 5'd18,
		PH_N4   = 5'd19
	} phase_t;

	// One tick of input.
	typedef struct packed {
		logic       start_request;
		logic       action;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} srm_in_t;

	// One tick of result.
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       ack_error;
	} srm_out_t;

	// Configuration handed to the engine.
	typedef struct packed {
		logic [7:0]  device_id;
		logic [15:0] half_period;
	} srm_cfg_t;

endpackage

[rtl/srm_if.sv]
// Request channel: one beat per bus tick.
interface srm_req_if;
	logic            valid;
	logic            ready;
	srm_pkg::srm_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Result channel: one beat per bus tick.
interface srm_res_if;
	logic             valid;
	logic             ready;
	srm_pkg::srm_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/srm_engine.sv]
module srm_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  srm_pkg::srm_in_t  item,
	input  srm_pkg::srm_cfg_t cfg,
	output srm_pkg::srm_out_t result
);
	import srm_pkg::*;

	// Protocol state.
	phase_t      phase_q;
	logic [15:0] delay_q;
	logic [3:0]  bit_q;
	logic [7:0]  shift_q;
	logic [1:0]  bidx_q;
	logic        read_q;
	logic [7:0]  reg_q;
	logic [7:0]  data_q;
	logic        err_q;
	logic [7:0]  rx_q;
	logic [2:0]  lvl_q;

	// State after a possible start of a transaction.
	phase_t      ph_a;
	logic [15:0] dly_a;
	logic [3:0]  bit_a;
	logic [7:0]  shift_a;
	logic [1:0]  bidx_a;
	logic        read_a;
	logic [7:0]  reg_a;
	logic [7:0]  data_a;
	logic        err_a;
	logic [2:0]  lvl_a;

	// Next state.
	phase_t      ph_n;
	logic [15:0] dly_n;
	logic [3:0]  bit_n;
	logic [7:0]  shift_n;
	logic [1:0]  bidx_n;
	logic        err_n;
	logic [7:0]  rx_n;
	logic [2:0]  lvl_n;
	logic        done;

	logic [15:0] hp_eff;
	logic [1:0]  load_idx;
	logic [7:0]  load_val;
	logic [7:0]  sh_tx;
	logic [7:0]  sh_rx;
	logic [3:0]  bit_inc;
	logic        held;

	// A half period of zero counts as one.
	assign hp_eff = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;

	// Start of a transaction, taken only while idle.
	always_comb begin
		ph_a    = phase_q;
		dly_a   = delay_q;
		bit_a   = bit_q;
		shift_a = shift_q;
		bidx_a  = bidx_q;
		read_a  = read_q;
		reg_a   = reg_q;
		data_a  = data_q;
		err_a   = err_q;
		lvl_a   = lvl_q;
		if (phase_q == PH_IDLE && item.start_request) begin
			ph_a    = PH_S1;
			dly_a   = hp_eff;
			bit_a   = 4'd0;
			shift_a = 8'd0;
			bidx_a  = 2'd0;
			read_a  = item.action;
			reg_a   = item.reg_addr;
			data_a  = item.write_data;
			err_a   = 1'b0;
			lvl_a   = LINES_IDLE;
		end
	end

	// Byte to send next; the gap after a byte moves on to the following one.
	always_comb begin
		load_idx = (ph_a == PH_GAP2) ? bidx_a + 2'd1 : bidx_a;
		case (load_idx)
			2'd0:    load_val = cfg.device_id;
			2'd1:    load_val = reg_a;
			default: load_val = read_a ? (cfg.device_id | READ_BIT) : data_a;
		endcase
	end

	assign sh_tx   = {shift_a[6:0], 1'b0};
	assign sh_rx   = {shift_a[6:0], item.sda_in};
	assign bit_inc = bit_a + 4'd1;
	assign held    = lvl_a[1];

	// Next state: count down the delay, then move to the next segment.
	always_comb begin
		ph_n    = ph_a;
		dly_n   = dly_a;
		bit_n   = bit_a;
		shift_n = shift_a;
		bidx_n  = bidx_a;
		err_n   = err_a;
		rx_n    = rx_q;
		lvl_n   = lvl_a;
		done    = 1'b0;
		if (ph_a != PH_IDLE) begin
			dly_n = (dly_a != 16'd0) ? dly_a - 16'd1 : 16'd0;
			if (dly_n == 16'd0) begin
				dly_n = hp_eff;
				case (ph_a)
					PH_S1: begin
						ph_n  = PH_S2;
						lvl_n = 3'b101;
					end
					PH_S2: begin
						shift_n = load_val;
						bit_n   = 4'd0;
						ph_n    = PH_BLO;
						lvl_n   = {1'b0, load_val[7], 1'b1};
					end
					PH_BLO: begin
						ph_n  = PH_BHI;
						lvl_n = {1'b1, held, 1'b1};
					end
					PH_BHI: begin
						shift_n = sh_tx;
						bit_n   = bit_inc;
						if (!bit_inc[3]) begin
							ph_n  = PH_BLO;
							lvl_n = {1'b0, sh_tx[7], 1'b1};
						end else begin
							ph_n  = PH_ALO;
							lvl_n = {1'b0, held, 1'b0};
						end
					end
					PH_ALO: begin
						ph_n  = PH_AHI;
						lvl_n = {1'b1, held, 1'b0};
					end
					PH_AHI: begin
						if (item.sda_in && !read_a) begin
							err_n = 1'b1;
						end
						if (!read_a && bidx_a == 2'd2) begin
							ph_n  = PH_P1;
							lvl_n = 3'b001;
						end else begin
							ph_n  = PH_GAP1;
							lvl_n = {1'b0, held, 1'b1};
						end
					end
					PH_GAP1: begin
						ph_n  = PH_GAP2;
						lvl_n = {1'b0, held, 1'b1};
					end
					PH_GAP2: begin
						if (!read_a || bidx_a == 2'd0) begin
							bidx_n  = load_idx;
							shift_n = load_val;
							bit_n   = 4'd0;
							ph_n    = PH_BLO;
							lvl_n   = {1'b0, load_val[7], 1'b1};
						end else if (bidx_a == 2'd1) begin
							ph_n  = PH_P1;
							lvl_n = 3'b001;
						end else begin
							bidx_n  = 2'd3;
							bit_n   = 4'd0;
							shift_n = 8'd0;
							ph_n    = PH_RLO;
							lvl_n   = {1'b0, held, 1'b0};
						end
					end
					PH_P1: begin
						ph_n  = PH_P2;
						lvl_n = 3'b101;
					end
					PH_P2: begin
						ph_n  = PH_P3;
						lvl_n = 3'b111;
					end
					PH_P3: begin
						if (read_a && bidx_a == 2'd1) begin
							ph_n  = PH_MID1;
							lvl_n = 3'b111;
						end else begin
							ph_n  = PH_IDLE;
							dly_n = 16'd0;
							bit_n = 4'd0;
							lvl_n = LINES_IDLE;
							done  = 1'b1;
						end
					end
					PH_MID1: begin
						ph_n  = PH_MID2;
						lvl_n = 3'b111;
					end
					PH_MID2: begin
						bidx_n = 2'd2;
						ph_n   = PH_S1;
						lvl_n  = 3'b111;
					end
					PH_RLO: begin
						ph_n  = PH_RHI;
						lvl_n = {1'b1, held, 1'b0};
					end
					PH_RHI: begin
						shift_n = sh_rx;
						bit_n   = bit_inc;
						if (!bit_inc[3]) begin
							ph_n  = PH_RLO;
							lvl_n = {1'b0, held, 1'b0};
						end else begin
							rx_n  = sh_rx;
							ph_n  = PH_N1;
							lvl_n = {1'b0, held, 1'b1};
						end
					end
					PH_N1: begin
						ph_n  = PH_N2;
						lvl_n = 3'b111;
					end
					PH_N2: begin
						ph_n  = PH_N3;
						lvl_n = 3'b011;
					end
					PH_N3: begin
						ph_n  = PH_N4;
						lvl_n = 3'b001;
					end
					PH_N4: begin
						ph_n  = PH_P1;
						lvl_n = 3'b001;
					end
					default: begin
						ph_n  = PH_IDLE;
						dly_n = 16'd0;
						lvl_n = LINES_IDLE;
					end
				endcase
			end
		end
	end

	// Result of this tick: line levels as they stood during the tick.
	always_comb begin
		result.scl_level = lvl_a[2];
		result.sda_level = lvl_a[0] ? lvl_a[1] : 1'b1;
		result.sda_drive = lvl_a[0];
		result.busy_res  = (ph_a != PH_IDLE);
		result.done_res  = done;
		result.read_byte = rx_n;
		result.ack_error = err_n;
	end

	// State registers advance once per worked tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			delay_q <= 16'd0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			bidx_q  <= 2'd0;
			read_q  <= 1'b0;
			reg_q   <= 8'd0;
			data_q  <= 8'd0;
			err_q   <= 1'b0;
			rx_q    <= 8'd0;
			lvl_q   <= LINES_IDLE;
		end else if (step) begin
			phase_q <= ph_n;
			delay_q <= dly_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			bidx_q  <= bidx_n;
			read_q  <= read_a;
			reg_q   <= reg_a;
			data_q  <= data_a;
			err_q   <= err_n;
			rx_q    <= rx_n;
			lvl_q   <= lvl_n;
		end
	end

endmodule

[rtl/sccb_register_master_unit.sv]
// A request beat is registered in the input register, worked once the result
// register is free or draining, and its result beat is then held there until taken.
// Throughput: one beat per cycle while res.ready is high; state updates once per beat.
// Reset (arst_n low, asynchronous): bus idle with clock and data high and driven,
// no transaction, error and read byte cleared, device id 66, half period 50.
module sccb_register_master_unit (
	input  logic        clk,
	input  logic        arst_n,
	srm_req_if.sink     req,
	srm_res_if.source   res,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);
	import srm_pkg::*;

	srm_cfg_t cfg_q;
	srm_in_t  item_s1;
	logic     valid_s1;
	srm_out_t res_q;
	logic     res_valid_q;
	srm_out_t step_res;
	logic     s1_fire;
	logic     req_fire;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_id   <= DEVICE_ID_RESET;
			cfg_q.half_period <= HALF_PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_DEVICE_ID:   cfg_q.device_id <= cfg_wdata[7:0];
				CFG_HALF_PERIOD: cfg_q.half_period <= cfg_wdata;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	// The input stage moves on when the result register is free or being drained.
	assign s1_fire   = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || s1_fire;
	assign req_fire  = req.valid && req.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_s1 <= req.data;
		end
	end

	srm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (step_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_q <= step_res;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// A finished transaction is still reported as busy on its last tick.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.done_res) |-> res_q.busy_res)
		else $error("done without busy");

	// Outside a transaction the bus rests with both lines high and driven.
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.busy_res) |->
		(res_q.scl_level && res_q.sda_level && res_q.sda_drive))
		else $error("bus not idle outside a transaction");

	// A worked beat always shows up in the result register.
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> res_valid_q)
		else $error("worked beat lost");

	// An accepted request beat is held in the input stage.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> valid_s1)
		else $error("accepted beat lost");

endmodule
